FILE: hw/rtl/utf8_stream_decoder_top_defines.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define UTF8D_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

   localparam int unsigned CodeWidth   = 21;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned MaxResults  = 4;

   localparam logic [7:0]  ContMask    = 8'hC0;
   localparam logic [7:0]  ContTag     = 8'h80;
   localparam logic [7:0]  Lead2Mask   = 8'hE0;
   localparam logic [7:0]  Lead2Tag    = 8'hC0;
   localparam logic [7:0]  Lead3Mask   = 8'hF0;
   localparam logic [7:0]  Lead3Tag    = 8'hE0;
   localparam logic [7:0]  Lead4Mask   = 8'hF8;
   localparam logic [7:0]  Lead4Tag    = 8'hF0;

   localparam logic [20:0] Min2        = 21'h000080;
   localparam logic [20:0] Min3        = 21'h000800;
   localparam logic [20:0] Min4        = 21'h010000;
   localparam logic [20:0] MaxCode     = 21'h10FFFF;
   localparam logic [20:0] SurrLow     = 21'h00D800;
   localparam logic [20:0] SurrHigh    = 21'h00DFFF;

   localparam logic [2:0]  LenNone     = 3'd0;
   localparam logic [2:0]  Len1        = 3'd1;
   localparam logic [2:0]  Len2        = 3'd2;
   localparam logic [2:0]  Len3        = 3'd3;
   localparam logic [2:0]  Len4        = 3'd4;

   // One result word.
   typedef struct packed {
      logic [CodeWidth-1:0]  code;
      logic                  valid;
      logic [CountWidth-1:0] count;
   } res_type;

   // All results caused by one input byte.
   typedef struct packed {
      res_type [MaxResults-1:0] ent;
      logic [2:0]               n;
   } burst_type;

   // Sequence state seen by the top level for checking.
   typedef struct packed {
      logic [2:0] exp_len;
      logic [1:0] rcv_cnt;
   } dec_status_type;

endpackage

FILE: hw/rtl/utf8d_core.sv
// Decoder state and the per-byte step: from the held sequence and one byte,
// builds the full list of results and the next state combinationally.
module utf8d_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  logic [7:0]                 data_byte,
   input  logic                       end_of_stream,
   output utf8d_pkg::burst_type       burst,
   output utf8d_pkg::dec_status_type  status
);

   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];
   logic [2:0]  exp_ff, exp_in;
   logic [1:0]  rcv_ff, rcv_in;
   logic [20:0] part_ff, part_in;

   function automatic utf8d_pkg::burst_type push(utf8d_pkg::burst_type b,
                                                 utf8d_pkg::res_type r);
      if (b.n < 3'(utf8d_pkg::MaxResults)) begin
         b.ent[b.n[1:0]] = r;
         b.n = b.n + 3'd1;
      end
      return b;
   endfunction

   function automatic utf8d_pkg::res_type raw(logic [7:0] b);
      utf8d_pkg::res_type r;
      r.code  = {13'd0, b};
      r.valid = 1'b0;
      r.count = 3'd1;
      return r;
   endfunction

   always_comb begin
      utf8d_pkg::burst_type bst;
      utf8d_pkg::res_type   r;
      logic                 do_flush;
      logic                 do_tail;
      logic                 do_lead;
      logic [20:0]          v;
      logic [20:0]          vmin;
      logic                 bad;
      logic [1:0]           held;

      bst      = '0;
      r        = '0;
      do_flush = 1'b0;
      do_tail  = 1'b0;
      do_lead  = 1'b0;
      pend_in  = pend_ff;
      exp_in   = exp_ff;
      rcv_in   = rcv_ff;
      part_in  = part_ff;
      v        = {part_ff[14:0], data_byte[5:0]};
      held     = rcv_ff;

      case (exp_ff)
         utf8d_pkg::Len2: vmin = utf8d_pkg::Min2;
         utf8d_pkg::Len3: vmin = utf8d_pkg::Min3;
         default:         vmin = utf8d_pkg::Min4;
      endcase
      bad = (v < vmin) || (v > utf8d_pkg::MaxCode) ||
            ((v >= utf8d_pkg::SurrLow) && (v <= utf8d_pkg::SurrHigh));

      if (exp_ff != utf8d_pkg::LenNone) begin
         if ((data_byte & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
            if (({1'b0, rcv_ff} + 3'd1) >= exp_ff) begin
               if (!bad) begin
                  r.code  = v;
                  r.valid = 1'b1;
                  r.count = exp_ff;
                  bst     = push(bst, r);
                  exp_in  = utf8d_pkg::LenNone;
                  rcv_in  = 2'd0;
                  part_in = '0;
               end else begin
                  do_flush = 1'b1;
                  do_tail  = 1'b1;
               end
            end else if (rcv_ff < 2'd3) begin
               pend_in[rcv_ff] = data_byte;
               rcv_in          = rcv_ff + 2'd1;
               part_in         = v;
            end else begin
               do_flush = 1'b1;
               do_tail  = 1'b1;
            end
         end else begin
            do_flush = 1'b1;
            do_lead  = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      // broken or rejected sequence: held bytes go out raw, in order
      if (do_flush) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < held) begin
               bst = push(bst, raw(pend_ff[i]));
            end
         end
         exp_in  = utf8d_pkg::LenNone;
         rcv_in  = 2'd0;
         part_in = '0;
      end
      if (do_tail) begin
         bst = push(bst, raw(data_byte));
      end

      if (do_lead) begin
         if (!data_byte[7]) begin
            r.code  = {13'd0, data_byte};
            r.valid = 1'b1;
            r.count = 3'd1;
            bst     = push(bst, r);
         end else if ((data_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag) begin
            pend_in[0] = data_byte;
            rcv_in     = 2'd1;
            exp_in     = utf8d_pkg::Len2;
            part_in    = {16'd0, data_byte[4:0]};
         end else if ((data_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag) begin
            pend_in[0] = data_byte;
            rcv_in     = 2'd1;
            exp_in     = utf8d_pkg::Len3;
            part_in    = {17'd0, data_byte[3:0]};
         end else if ((data_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag) begin
            pend_in[0] = data_byte;
            rcv_in     = 2'd1;
            exp_in     = utf8d_pkg::Len4;
            part_in    = {18'd0, data_byte[2:0]};
         end else begin
            bst = push(bst, raw(data_byte));
         end
      end

      // end of stream drains whatever is still held
      if (end_of_stream && (exp_in != utf8d_pkg::LenNone)) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < rcv_in) begin
               bst = push(bst, raw(pend_in[i]));
            end
         end
         exp_in  = utf8d_pkg::LenNone;
         rcv_in  = 2'd0;
         part_in = '0;
      end

      burst = bst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= utf8d_pkg::LenNone;
         rcv_ff  <= 2'd0;
         part_ff <= '0;
      end else if (step_en) begin
         exp_ff  <= exp_in;
         rcv_ff  <= rcv_in;
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         pend_ff <= pend_in;
      end
   end

   assign status.exp_len = exp_ff;
   assign status.rcv_cnt = rcv_ff;

endmodule

FILE: hw/rtl/utf8_stream_decoder_top.sv
// channel | dir | handshake            | tdata                        | tuser / tlast
// req     | in  | req_tvalid/tready    | [7:0] data_byte              | tlast end_of_stream
// rsp     | out | rsp_tvalid/tready    | [20:0] code_value,           | tuser is_valid,
//         |     |                      | [23:21] byte_count           | tlast last_of_run
//
// One byte per cycle when each byte yields at most one word; a byte that
// yields several words holds the input side while the result buffer
// drains, one word per cycle. Stages: input register, then result buffer.
// Synchronous active-high reset clears the sequence state and both stages;
// no clearing pass. A stall on rsp halts both rates, backing up through the
// result buffer into the input register, then to req_tready.
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // end_of_stream
   // decoded result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [20:0] code_value, [23:21] byte_count
   output logic        rsp_tuser,    // [0] is_valid
   output logic        rsp_tlast     // last_of_run
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // result buffer: all words of one byte, read out in order
   utf8d_pkg::burst_type buf_ff;
   logic [2:0]           buf_cnt_ff, buf_cnt_in;
   logic [1:0]           rd_ff, rd_in;

   utf8d_pkg::burst_type      burst;
   utf8d_pkg::dec_status_type status;
   utf8d_pkg::res_type        cur;

   logic req_fire;
   logic rsp_fire;
   logic rsp_last;
   logic buf_free;
   logic process;

   assign rsp_tvalid = (buf_cnt_ff != 3'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_last   = ({1'b0, rd_ff} == (buf_cnt_ff - 3'd1));

   // buffer can take a new burst when empty or when its final word leaves now
   assign buf_free   = (buf_cnt_ff == 3'd0) || (rsp_fire && rsp_last);
   assign process    = in_vld_ff && buf_free;
   assign req_tready = !in_vld_ff || process;
   assign req_fire   = req_tvalid && req_tready;

   utf8d_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (process),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .burst         (burst),
      .status        (status)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (process) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      rd_in      = rd_ff;
      if (process) begin
         buf_cnt_in = burst.n;
         rd_in      = 2'd0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            buf_cnt_in = 3'd0;
            rd_in      = 2'd0;
         end else begin
            rd_in = rd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         buf_cnt_ff <= 3'd0;
         rd_ff      <= 2'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         buf_cnt_ff <= buf_cnt_in;
         rd_ff      <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
      if (process) begin
         buf_ff <= burst;
      end
   end

   assign cur       = buf_ff.ent[rd_ff];
   assign rsp_tdata = {cur.count, cur.code};
   assign rsp_tuser = cur.valid;
   assign rsp_tlast = rsp_last;

   // read pointer stays inside the loaded burst
   `UTF8D_ASSERT_NOW(a_rd_in_range, rsp_tvalid, ({1'b0, rd_ff} < buf_cnt_ff), "read index past burst")
   // an open sequence holds at least one byte and fewer than its length
   `UTF8D_ASSERT_NOW(a_open_seq, (status.exp_len != utf8d_pkg::LenNone), ((status.rcv_cnt != 2'd0) && ({1'b0, status.rcv_cnt} < status.exp_len)), "bad sequence state")
   // end of stream always leaves the decoder with no open sequence
   `UTF8D_ASSERT_NEXT(a_eos_closes, (process && in_eos_ff), (status.exp_len == utf8d_pkg::LenNone), "sequence open after end of stream")

endmodule
